// ----- src/sow_pkg.sv -----
// Shared types and constants for the spiral order walker.
package sow_pkg;

   localparam int SOW_MAX_ROWS    = 16;
   localparam int SOW_MAX_COLS    = 16;
   localparam int SOW_VALUE_WIDTH = 32;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   localparam int ELEM_W = 32;
   localparam int IDX_W  = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS = 1'd1;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_FETCH = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      DIR_RIGHT = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_UP    = 2'd3
   } dir_type;

   typedef struct packed {
      logic                     op;
      logic signed [ELEM_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic [IDX_W-1:0]         row_index;
      logic [IDX_W-1:0]         col_index;
      logic                     last;
   } rsp_type;

endpackage

// ----- src/sow_store.sv -----
// Matrix storage: one write port, one read port, registered read data.
module sow_store #(
   parameter int DEPTH = 256,
   parameter int AW    = 8,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/spiral_order_walker_unit.sv -----
// Top level of the spiral order walker: load cursor, spiral walker and result stage.
//
//   channel   ports                          direction  qualifier
//   request   start, busy, req_data          in         start & !busy
//   response  rsp_valid, rsp_data            out        rsp_valid, one cycle
//   csr       csr_we, csr_index, csr_wdata   in         csr_we
//
// One transaction per cycle; busy stays low. A fetch reads the matrix store at the
// spiral cursor, so its result appears in the cycle after acceptance (registered store read).
// A load writes the store at the row-major cursor and gives no result.
// Reset clears the cursors and bounds; store contents are undefined until loaded.
// The receiver cannot stall the response; each result is shown for exactly one cycle.
module spiral_order_walker_unit #(
   parameter int MAX_ROWS    = sow_pkg::SOW_MAX_ROWS,
   parameter int MAX_COLS    = sow_pkg::SOW_MAX_COLS,
   parameter int VALUE_WIDTH = sow_pkg::SOW_VALUE_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  sow_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   output sow_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [sow_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sow_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import sow_pkg::*;

   localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CLW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int EW      = $clog2(MAX_DIM + 1);
   localparam int BW      = EW + 1;
   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW      = $clog2(DEPTH + 1);
   localparam int TW      = 2 * EW;

   logic [CSR_DATA_W-1:0] num_rows_ff, num_cols_ff;
   logic [CSR_DATA_W-1:0] num_rows_in, num_cols_in;
   logic [EW-1:0]         eff_rows, eff_cols;
   logic [EW-1:0]         new_rows, new_cols;
   logic [TW-1:0]         total;

   logic [RW-1:0]  load_row_ff, load_row_in;
   logic [CLW-1:0] load_col_ff, load_col_in;

   logic signed [BW-1:0] left_ff, right_ff, top_ff, bottom_ff;
   logic signed [BW-1:0] left_in, right_in, top_in, bottom_in;
   logic signed [BW-1:0] cur_row_ff, cur_col_ff, cur_row_in, cur_col_in;
   dir_type              dir_ff, dir_in;
   logic [CW-1:0]        count_ff, count_in;

   logic accept, do_load, do_fetch, is_last, restart;

   logic                   rsp_valid_ff;
   logic [RW-1:0]          rsp_row_ff;
   logic [CLW-1:0]         rsp_col_ff;
   logic                   rsp_last_ff;

   logic [AW-1:0]          wr_addr, rd_addr;
   logic [VALUE_WIDTH-1:0] wr_data, rd_data;
   logic [VALUE_WIDTH+ELEM_W-1:0] wr_wide, rd_wide;

   // Size code to size in use: zero acts as one, oversize clamps to the maximum.
   function automatic logic [EW-1:0] clip_dim(input logic [CSR_DATA_W-1:0] code,
                                              input int limit);
      if (code == '0) return EW'(1);
      if (32'(code) > limit) return EW'(limit);
      return EW'(code);
   endfunction

   assign busy     = 1'b0;
   assign accept   = start & ~busy;
   assign do_load  = accept & (req_data.op == OP_LOAD);
   assign do_fetch = accept & (req_data.op == OP_FETCH);

   // Current sizes drive the cursors; a register write restarts at the new sizes.
   always_comb begin
      eff_rows = clip_dim(num_rows_ff, MAX_ROWS);
      eff_cols = clip_dim(num_cols_ff, MAX_COLS);
      new_rows = clip_dim(num_rows_in, MAX_ROWS);
      new_cols = clip_dim(num_cols_in, MAX_COLS);
   end

   assign total   = TW'(eff_rows) * TW'(eff_cols);
   assign is_last = (32'(count_ff) + 1) >= 32'(total);
   assign restart = csr_we | (do_fetch & is_last);

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_ROWS: num_rows_in = csr_wdata;
            CSR_NUM_COLS: num_cols_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= CSR_DATA_W'(1);
         num_cols_ff <= CSR_DATA_W'(1);
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
      end
   end

   // Row-major load cursor.
   always_comb begin
      load_row_in = load_row_ff;
      load_col_in = load_col_ff;
      if (csr_we) begin
         load_row_in = '0;
         load_col_in = '0;
      end else if (do_load) begin
         if (32'(load_col_ff) + 1 >= 32'(eff_cols)) begin
            load_col_in = '0;
            if (32'(load_row_ff) + 1 >= 32'(eff_rows)) load_row_in = '0;
            else load_row_in = load_row_ff + RW'(1);
         end else begin
            load_col_in = load_col_ff + CLW'(1);
         end
      end
   end

   // Spiral walker: bounds shrink as each side is finished.
   always_comb begin
      left_in    = left_ff;
      right_in   = right_ff;
      top_in     = top_ff;
      bottom_in  = bottom_ff;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      dir_in     = dir_ff;
      count_in   = count_ff;
      if (restart) begin
         left_in    = '0;
         top_in     = '0;
         right_in   = BW'(new_cols) - BW'(1);
         bottom_in  = BW'(new_rows) - BW'(1);
         cur_row_in = '0;
         cur_col_in = '0;
         dir_in     = DIR_RIGHT;
         count_in   = '0;
      end else if (do_fetch) begin
         count_in = count_ff + CW'(1);
         unique case (dir_ff)
            DIR_RIGHT: begin
               if (cur_col_ff < right_ff) begin
                  cur_col_in = cur_col_ff + BW'(1);
               end else begin
                  top_in     = top_ff + BW'(1);
                  dir_in     = DIR_DOWN;
                  cur_row_in = top_ff + BW'(1);
                  cur_col_in = right_ff;
               end
            end
            DIR_DOWN: begin
               if (cur_row_ff < bottom_ff) begin
                  cur_row_in = cur_row_ff + BW'(1);
               end else begin
                  right_in   = right_ff - BW'(1);
                  dir_in     = DIR_LEFT;
                  cur_col_in = right_ff - BW'(1);
                  cur_row_in = bottom_ff;
               end
            end
            DIR_LEFT: begin
               if (cur_col_ff > left_ff) begin
                  cur_col_in = cur_col_ff - BW'(1);
               end else begin
                  bottom_in  = bottom_ff - BW'(1);
                  dir_in     = DIR_UP;
                  cur_row_in = bottom_ff - BW'(1);
                  cur_col_in = left_ff;
               end
            end
            DIR_UP: begin
               if (cur_row_ff > top_ff) begin
                  cur_row_in = cur_row_ff - BW'(1);
               end else begin
                  left_in    = left_ff + BW'(1);
                  dir_in     = DIR_RIGHT;
                  cur_col_in = left_ff + BW'(1);
                  cur_row_in = top_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_row_ff  <= '0;
         load_col_ff  <= '0;
         left_ff      <= '0;
         top_ff       <= '0;
         right_ff     <= '0;
         bottom_ff    <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         dir_ff       <= DIR_RIGHT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         load_row_ff  <= load_row_in;
         load_col_ff  <= load_col_in;
         left_ff      <= left_in;
         top_ff       <= top_in;
         right_ff     <= right_in;
         bottom_ff    <= bottom_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         dir_ff       <= dir_in;
         count_ff     <= count_in;
         rsp_valid_ff <= do_fetch;
      end
   end

   // Sideband of the result, aligned with the store read data.
   always_ff @(posedge clock) begin
      if (do_fetch) begin
         rsp_row_ff  <= cur_row_ff[RW-1:0];
         rsp_col_ff  <= cur_col_ff[CLW-1:0];
         rsp_last_ff <= is_last;
      end
   end

   assign wr_addr = AW'(32'(load_row_ff) * MAX_COLS + 32'(load_col_ff));
   assign rd_addr = AW'(32'(cur_row_ff[RW-1:0]) * MAX_COLS + 32'(cur_col_ff[CLW-1:0]));
   assign wr_wide = {{VALUE_WIDTH{1'b0}}, req_data.value};
   assign wr_data = wr_wide[VALUE_WIDTH-1:0];
   assign rd_wide = {{ELEM_W{1'b0}}, rd_data};

   sow_store #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (VALUE_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_load),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (do_fetch),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data.element   = rd_wide[ELEM_W-1:0];
   assign rsp_data.row_index = IDX_W'(rsp_row_ff);
   assign rsp_data.col_index = IDX_W'(rsp_col_ff);
   assign rsp_data.last      = rsp_last_ff;

endmodule

// ----- tb/spiral_result_checker.sv -----
// Checker for the spiral order walker: mirrors the matrix and the walk, compares each result.
module spiral_result_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic                             busy,
   input  sow_pkg::req_type                 req_data,
   input  logic                             rsp_valid,
   input  sow_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [sow_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sow_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                               mismatch_count,
   output int                               results_due
);

   import sow_pkg::*;

   logic signed [ELEM_W-1:0] store_mem [SOW_MAX_ROWS*SOW_MAX_COLS];
   logic [CSR_DATA_W-1:0]    rows_reg;
   logic [CSR_DATA_W-1:0]    cols_reg;
   int                       fill_at;
   int                       lo_row, hi_row, lo_col, hi_col;
   int                       at_row, at_col;
   int                       walked;
   dir_type                  heading;
   rsp_type                  due_results [$];

   initial begin
      mismatch_count = 0;
      results_due    = 0;
      foreach (store_mem[i]) store_mem[i] = '0;
   end

   // out-of-range size codes saturate; the register itself keeps the raw bits
   function automatic int clip_size(input logic [CSR_DATA_W-1:0] v, input int max_size);
      if (v == 0) return 1;
      if (v > max_size) return max_size;
      return int'(v);
   endfunction

   function automatic int store_slot(input int r, input int c);
      if (r < 0 || r >= SOW_MAX_ROWS || c < 0 || c >= SOW_MAX_COLS) return 0;
      return r * SOW_MAX_COLS + c;
   endfunction

   task automatic rewind_spiral();
      lo_row  = 0;
      lo_col  = 0;
      hi_row  = clip_size(rows_reg, SOW_MAX_ROWS) - 1;
      hi_col  = clip_size(cols_reg, SOW_MAX_COLS) - 1;
      heading = DIR_RIGHT;
      at_row  = 0;
      at_col  = 0;
      walked  = 0;
   endtask

   // one spiral step; a finished side shrinks its bound and turns clockwise
   task automatic move_cursor();
      case (heading)
         DIR_RIGHT: begin
            if (at_col < hi_col) at_col++;
            else begin
               lo_row++;
               heading = DIR_DOWN;
               at_row  = lo_row;
               at_col  = hi_col;
            end
         end
         DIR_DOWN: begin
            if (at_row < hi_row) at_row++;
            else begin
               hi_col--;
               heading = DIR_LEFT;
               at_col  = hi_col;
               at_row  = hi_row;
            end
         end
         DIR_LEFT: begin
            if (at_col > lo_col) at_col--;
            else begin
               hi_row--;
               heading = DIR_UP;
               at_row  = hi_row;
               at_col  = lo_col;
            end
         end
         default: begin
            if (at_row > lo_row) at_row--;
            else begin
               lo_col++;
               heading = DIR_RIGHT;
               at_col  = lo_col;
               at_row  = lo_row;
            end
         end
      endcase
   endtask

   task automatic predict_item(input req_type item);
      int      n_rows;
      int      n_cols;
      int      cells;
      int      pos;
      rsp_type res;
      n_rows = clip_size(rows_reg, SOW_MAX_ROWS);
      n_cols = clip_size(cols_reg, SOW_MAX_COLS);
      cells  = n_rows * n_cols;
      if (item.op == OP_LOAD) begin
         pos = fill_at % cells;
         store_mem[store_slot(pos / n_cols, pos % n_cols)] = item.value;
         pos++;
         fill_at = (pos >= cells) ? 0 : pos;
      end else begin
         res.element   = store_mem[store_slot(at_row, at_col)];
         res.row_index = at_row[IDX_W-1:0];
         res.col_index = at_col[IDX_W-1:0];
         res.last      = (walked + 1 >= cells);
         due_results.insert(due_results.size(), res);
         if (res.last) rewind_spiral();
         else begin
            walked++;
            move_cursor();
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rows_reg = CSR_DATA_W'(1);
         cols_reg = CSR_DATA_W'(1);
         fill_at  = 0;
         rewind_spiral();
         due_results.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_NUM_ROWS) rows_reg = csr_wdata;
            else cols_reg = csr_wdata;
            fill_at = 0;
            rewind_spiral();
         end
         // predict first so a same-edge result would still find its expectation
         if (start && !busy) predict_item(req_data);
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               $error("unexpected result: element %0d row %0d col %0d last %0d",
                      rsp_data.element, rsp_data.row_index, rsp_data.col_index,
                      rsp_data.last);
               mismatch_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_data.element !== want.element) begin
                  $error("element: expected %0d, actual %0d", want.element, rsp_data.element);
                  mismatch_count++;
               end
               if (rsp_data.row_index !== want.row_index) begin
                  $error("row_index: expected %0d, actual %0d",
                         want.row_index, rsp_data.row_index);
                  mismatch_count++;
               end
               if (rsp_data.col_index !== want.col_index) begin
                  $error("col_index: expected %0d, actual %0d",
                         want.col_index, rsp_data.col_index);
                  mismatch_count++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_data.last);
                  mismatch_count++;
               end
            end
         end
      end
      results_due <= due_results.size();
   end

endmodule

// ----- tb/tb.sv -----
// Testbench top for the spiral order walker: stimulus, watchdog and verdict.
module tb;
   import sow_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int ITEM_TARGET = 400;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   req_type               req_data  = '0;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_NUM_ROWS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  busy;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   int                    mismatch_count;
   int                    results_due;
   int                    stall_cycles = 0;
   int                    items_sent   = 0;

   // stimulus bookkeeping: which store entries hold a loaded value
   bit                    filled [SOW_MAX_ROWS*SOW_MAX_COLS];
   int                    fill_pos = 0;
   logic [CSR_DATA_W-1:0] rows_raw = CSR_DATA_W'(1);
   logic [CSR_DATA_W-1:0] cols_raw = CSR_DATA_W'(1);
   bit                    no_idle  = 1'b0;

   always #10 clock = ~clock;

   spiral_order_walker_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   spiral_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic int used_size(input logic [CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > SOW_MAX_ROWS) return SOW_MAX_ROWS;
      return int'(v);
   endfunction

   function automatic int region_cells();
      return used_size(rows_raw) * used_size(cols_raw);
   endfunction

   function automatic bit region_loaded();
      for (int r = 0; r < used_size(rows_raw); r++)
         for (int c = 0; c < used_size(cols_raw); c++)
            if (!filled[r*SOW_MAX_COLS + c]) return 1'b0;
      return 1'b1;
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_size();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return '0;
      if (roll < 10) return CSR_DATA_W'(SOW_MAX_ROWS);
      if (roll < 15) return CSR_DATA_W'($urandom_range(SOW_MAX_ROWS + 1, 31));
      return CSR_DATA_W'($urandom_range(1, 6));
   endfunction

   task automatic send_req(input op_type op, input logic signed [ELEM_W-1:0] v);
      int gap;
      int pos;
      start    <= 1'b1;
      req_data <= '{op: op, value: v};
      do @(posedge clock); while (busy);
      items_sent++;
      if (op == OP_LOAD) begin
         pos = fill_pos;
         filled[(pos / used_size(cols_raw)) * SOW_MAX_COLS + pos % used_size(cols_raw)] = 1'b1;
         fill_pos = (pos + 1 >= region_cells()) ? 0 : pos + 1;
      end
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drain outstanding results; loads give none, so settle also idles after the queue is empty
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_NUM_ROWS) rows_raw = v;
      else cols_raw = v;
      fill_pos = 0;
   endtask

   initial begin
      int n;
      int cells;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 1x1 after reset: value extremes, every fetch is the last one
      send_req(OP_LOAD, 32'sh8000_0000);
      send_req(OP_FETCH, $urandom);
      send_req(OP_LOAD, 32'sh7FFF_FFFF);
      send_req(OP_FETCH, '0);

      // zero row code behaves as one row: single row walk, then wrap
      write_reg(CSR_NUM_ROWS, CSR_DATA_W'(0));
      write_reg(CSR_NUM_COLS, CSR_DATA_W'(3));
      send_req(OP_LOAD, -1);
      send_req(OP_LOAD, 0);
      send_req(OP_LOAD, 1);
      repeat (4) send_req(OP_FETCH, $urandom);

      // single column, zero column code
      write_reg(CSR_NUM_COLS, CSR_DATA_W'(0));
      write_reg(CSR_NUM_ROWS, CSR_DATA_W'(3));
      repeat (3) send_req(OP_LOAD, $urandom);
      repeat (3) send_req(OP_FETCH, $urandom);

      // full-height matrix, row code above the maximum
      write_reg(CSR_NUM_ROWS, CSR_DATA_W'(31));
      write_reg(CSR_NUM_COLS, CSR_DATA_W'(SOW_MAX_COLS / 2));
      no_idle = 1'b1;
      repeat (region_cells()) send_req(OP_LOAD, $urandom);
      no_idle = 1'b0;
      repeat (region_cells() + 4) send_req(OP_FETCH, $urandom);

      while (items_sent < ITEM_TARGET) begin
         no_idle = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 2))
            0: write_reg(CSR_NUM_ROWS, pick_size());
            1: write_reg(CSR_NUM_COLS, pick_size());
            default: begin
               write_reg(CSR_NUM_ROWS, pick_size());
               write_reg(CSR_NUM_COLS, pick_size());
            end
         endcase
         cells = region_cells();
         // full load where needed, else a partial one so fetches overlap a load
         n = region_loaded() ? $urandom_range(0, cells - 1) : cells;
         repeat (n) send_req(OP_LOAD, $urandom);
         n = $urandom_range(cells, 2 * cells + 4);
         repeat (n) begin
            if ($urandom_range(0, 3) == 0) send_req(OP_LOAD, $urandom);
            else send_req(OP_FETCH, $urandom);
         end
      end

      settle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
